// File: rtl/lps_pkg.sv
// ---------------------------------------------------------------------------
// lps_pkg
// shared types and constants of the led pattern sequencer
// ---------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  localparam int NumLedsDefault   = 4;
  localparam int PatternLenDefault = 8;
  localparam int CfgIndexW        = 2;
  localparam int CfgDataW         = 64;
  localparam int PolarityW        = 4;
  localparam int PinsW            = 4;

  // command codes
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_SET_LEVEL = 3'd1,
    CMD_SET_STAT  = 3'd2,
    CMD_RESTART   = 3'd3,
    CMD_STOP      = 3'd4,
    CMD_BLINK     = 3'd5,
    CMD_SET_DELAY = 3'd6
  } cmd_t;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_PAT_CONN    = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_PAT_NOCONN  = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_PAT_LOST    = 2'd2;
  localparam logic [CfgIndexW-1:0] CFG_POLARITY    = 2'd3;

  localparam logic [PolarityW-1:0] POLARITY_RESET = 4'hF;

  // status / pattern choice codes
  localparam logic [1:0] STAT_CONN   = 2'd0;
  localparam logic [1:0] STAT_NOCONN = 2'd1;
  localparam logic [1:0] STAT_LOST   = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] led_index;
    logic [7:0] argument;
  } in_beat_t;

  typedef struct packed {
    logic [PinsW-1:0] pin_levels;
    logic [PinsW-1:0] playing_mask;
  } out_beat_t;

  // per-led entry kept in the state memory
  typedef struct packed {
    logic       blink_pending;
    logic [2:0] step_index;
    logic [7:0] tick_count;
    logic [7:0] start_delay;
    logic [1:0] conn_status;
    logic [1:0] pattern_choice;
  } led_entry_t;

  // per-led flags kept in flops (they feed every result beat)
  typedef struct packed {
    logic lit;
    logic playing;
  } led_flags_t;

  // command context handed to the update unit
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] argument;
  } led_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE,
    S_DONE
  } seq_state_t;

endpackage

`default_nettype wire

// File: rtl/lps_led_update.sv
// ---------------------------------------------------------------------------
// lps_led_update
// next entry and flags of one led for one command or tick
// ---------------------------------------------------------------------------
`default_nettype none

module lps_led_update #(
  parameter int PATTERN_LEN = lps_pkg::PatternLenDefault
) (
  input  lps_pkg::led_cmd_t   cmd,
  input  lps_pkg::led_entry_t entry,
  input  lps_pkg::led_flags_t flags,
  input  logic [63:0]         pat_conn,
  input  logic [63:0]         pat_noconn,
  input  logic [63:0]         pat_lost,
  output lps_pkg::led_entry_t entry_next,
  output lps_pkg::led_flags_t flags_next
);

  localparam logic [3:0] LenLimit = 4'(PATTERN_LEN);

  logic [63:0] pat;
  logic [7:0]  cur_dur;
  logic [7:0]  nxt_dur;
  logic [3:0]  nxt;

  always_comb begin
    case (entry.pattern_choice)
      lps_pkg::STAT_NOCONN: pat = pat_noconn;
      lps_pkg::STAT_LOST:   pat = pat_lost;
      default:              pat = pat_conn;
    endcase
  end

  assign nxt     = {1'b0, entry.step_index} + 4'd1;
  assign cur_dur = pat[{entry.step_index, 3'b000} +: 8];
  assign nxt_dur = pat[{nxt[2:0], 3'b000} +: 8];

  always_comb begin
    entry_next = entry;
    flags_next = flags;
    unique case (cmd.command)
      lps_pkg::CMD_TICK: begin
        if (flags.playing) begin
          if (entry.start_delay != 8'd0) begin
            entry_next.start_delay = entry.start_delay - 8'd1;
          end else if (entry.tick_count >= cur_dur) begin
            entry_next.tick_count = 8'd0;
            if (nxt >= LenLimit || nxt_dur == 8'd0) begin
              // wrap: back to entry 0, lit
              flags_next.lit         = 1'b1;
              entry_next.step_index  = 3'd0;
            end else begin
              flags_next.lit         = ~flags.lit;
              entry_next.step_index  = nxt[2:0];
            end
          end else begin
            entry_next.tick_count = entry.tick_count + 8'd1;
          end
        end else if (entry.blink_pending) begin
          flags_next.lit           = 1'b1;
          entry_next.blink_pending = 1'b0;
        end else begin
          flags_next.lit = 1'b0;
        end
      end
      lps_pkg::CMD_SET_LEVEL: begin
        flags_next.playing = 1'b0;
        flags_next.lit     = cmd.argument[0];
      end
      lps_pkg::CMD_SET_STAT: begin
        if (cmd.argument <= 8'd2 &&
            !(entry.conn_status == cmd.argument[1:0] && flags.playing)) begin
          entry_next.conn_status    = cmd.argument[1:0];
          entry_next.pattern_choice = cmd.argument[1:0];
          entry_next.step_index     = 3'd0;
          entry_next.tick_count     = 8'd0;
          flags_next.playing        = 1'b1;
          flags_next.lit            = 1'b1;
        end
      end
      lps_pkg::CMD_RESTART: begin
        entry_next.step_index = 3'd0;
        entry_next.tick_count = 8'd0;
        flags_next.playing    = 1'b1;
        flags_next.lit        = 1'b1;
      end
      lps_pkg::CMD_STOP: begin
        flags_next.playing = 1'b0;
        flags_next.lit     = 1'b0;
      end
      lps_pkg::CMD_BLINK: begin
        flags_next.playing       = 1'b0;
        entry_next.blink_pending = 1'b1;
      end
      lps_pkg::CMD_SET_DELAY: begin
        entry_next.start_delay = cmd.argument;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/led_pattern_sequencer.sv
// ---------------------------------------------------------------------------
// led_pattern_sequencer
// per-led blink pattern player with a read-modify-write state memory
// ---------------------------------------------------------------------------
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, in_data          | command beats in
//  out     | out_valid, out_stall, out_data       | one result beat per command
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register writes
//
//  a command passes through accept, memory read, update and write back,
//  and result load; a non-tick command to a missing led skips the memory.
//  a tick reads then writes each led entry through the single memory port.
//  rst is synchronous; it clears the entry valid bits, so every led reads
//  as all-zero state until first written, and no clearing pass is needed.
//  a stalled result holds in the output register; the sequencer waits in
//  its final state until that register is free.
//
`default_nettype none

module led_pattern_sequencer #(
  parameter int NUM_LEDS    = lps_pkg::NumLedsDefault,
  parameter int PATTERN_LEN = lps_pkg::PatternLenDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lps_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lps_pkg::out_beat_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lps_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [lps_pkg::CfgDataW-1:0]    cfg_data
);

  localparam int LedW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [LedW-1:0] LastLed = LedW'(NUM_LEDS - 1);

  // configuration registers
  logic [63:0] pat_conn;
  logic [63:0] pat_noconn;
  logic [63:0] pat_lost;
  logic [lps_pkg::PolarityW-1:0] polarity;

  // latched command
  logic [2:0] cmd;
  logic [7:0] arg;
  logic       is_tick;
  logic [LedW-1:0] cur;

  // per-led flags in flops, rest of the state in memory
  logic [NUM_LEDS-1:0] lit;
  logic [NUM_LEDS-1:0] playing;
  logic [NUM_LEDS-1:0] entry_valid;
  lps_pkg::led_entry_t mem [NUM_LEDS];
  lps_pkg::led_entry_t rd_data;
  logic                rd_valid;

  lps_pkg::seq_state_t state, state_next;

  logic                accept;
  logic                led_in_range;
  logic                rd_en;
  logic                wr_en;
  logic                load_out;
  logic                last_led;
  lps_pkg::led_entry_t entry_cur;
  lps_pkg::led_entry_t entry_new;
  lps_pkg::led_flags_t flags_cur;
  lps_pkg::led_flags_t flags_new;
  lps_pkg::led_cmd_t   upd_cmd;
  logic [15:0]         lit_wide;
  logic [15:0]         play_wide;
  lps_pkg::out_beat_t  result;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != lps_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign led_in_range = (32'(in_data.led_index) < NUM_LEDS);
  assign last_led  = (cur == LastLed);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_conn   <= '0;
      pat_noconn <= '0;
      pat_lost   <= '0;
      polarity   <= lps_pkg::POLARITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lps_pkg::CFG_PAT_CONN:   pat_conn   <= cfg_data;
        lps_pkg::CFG_PAT_NOCONN: pat_noconn <= cfg_data;
        lps_pkg::CFG_PAT_LOST:   pat_lost   <= cfg_data;
        lps_pkg::CFG_POLARITY:   polarity   <= cfg_data[lps_pkg::PolarityW-1:0];
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lps_pkg::S_IDLE: begin
        if (accept) begin
          // non-tick commands to a missing led change nothing
          if (in_data.command == lps_pkg::CMD_TICK || led_in_range) begin
            state_next = lps_pkg::S_READ;
          end else begin
            state_next = lps_pkg::S_DONE;
          end
        end
      end
      lps_pkg::S_READ: state_next = lps_pkg::S_WRITE;
      lps_pkg::S_WRITE: begin
        if (is_tick && !last_led) begin
          state_next = lps_pkg::S_READ;
        end else begin
          state_next = lps_pkg::S_DONE;
        end
      end
      lps_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = lps_pkg::S_IDLE;
        end
      end
      default: state_next = lps_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      lps_pkg::S_READ:  rd_en    = 1'b1;
      lps_pkg::S_WRITE: wr_en    = 1'b1;
      lps_pkg::S_DONE:  load_out = !out_valid || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command latch and led walk pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= in_data.command;
      arg     <= in_data.argument;
      is_tick <= (in_data.command == lps_pkg::CMD_TICK);
      cur     <= (in_data.command == lps_pkg::CMD_TICK) ? '0 : LedW'(in_data.led_index);
    end else if (wr_en && is_tick && !last_led) begin
      cur <= cur + LedW'(1);
    end
  end

  // state memory, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[cur];
    end
    if (wr_en) begin
      mem[cur] <= entry_new;
    end
  end

  // valid bits: unwritten entries read as zero state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid <= entry_valid[cur];
      end
      if (wr_en) begin
        entry_valid[cur] <= 1'b1;
      end
    end
  end

  assign entry_cur = rd_valid ? rd_data : '0;
  assign flags_cur = '{lit: lit[cur], playing: playing[cur]};
  assign upd_cmd   = '{command: cmd, argument: arg};

  lps_led_update #(
    .PATTERN_LEN (PATTERN_LEN)
  ) u_update (
    .cmd        (upd_cmd),
    .entry      (entry_cur),
    .flags      (flags_cur),
    .pat_conn   (pat_conn),
    .pat_noconn (pat_noconn),
    .pat_lost   (pat_lost),
    .entry_next (entry_new),
    .flags_next (flags_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lit     <= '0;
      playing <= '0;
    end else if (wr_en) begin
      lit[cur]     <= flags_new.lit;
      playing[cur] <= flags_new.playing;
    end
  end

  // result: pin level is lit passed through polarity, missing leds read 0
  assign lit_wide  = 16'(lit);
  assign play_wide = 16'(playing);

  always_comb begin
    result = '0;
    for (int i = 0; i < lps_pkg::PinsW; i++) begin
      if (i < NUM_LEDS) begin
        result.pin_levels[i]   = ~(lit_wide[i] ^ polarity[i]);
        result.playing_mask[i] = play_wide[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire
